// File: rtl/core/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms, compiled out when ASSERT_OFF is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define ASSERT_PROP(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);
`else
`define ASSERT_PROP(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, cond, msg)
`endif

`endif

// File: rtl/core/rbs_pkg.sv
// ----------------------------------------------------------------------------
// Retransmit backoff scheduler package
// Codes, constants and the structures passed between the scheduler modules.
// ----------------------------------------------------------------------------
package rbs_pkg;

    localparam int unsigned MAX_RETRIES = 6;

    localparam logic [31:0] BASE_DELAY_MS = 32'd64;
    localparam logic [31:0] GRACE_MS      = 32'd64;

    localparam logic [1:0] ACT_POLL  = 2'd0;
    localparam logic [1:0] ACT_ACK   = 2'd1;
    localparam logic [1:0] ACT_DONE  = 2'd2;
    localparam logic [1:0] ACT_ABORT = 2'd3;

    localparam logic [1:0] CH_NONE = 2'd0;
    localparam logic [1:0] CH_RED  = 2'd1;
    localparam logic [1:0] CH_BLUE = 2'd2;

    localparam logic [1:0] CAUSE_NONE       = 2'd0;
    localparam logic [1:0] CAUSE_ACKED      = 2'd1;
    localparam logic [1:0] CAUSE_EXHAUSTED  = 2'd2;
    localparam logic [1:0] CAUSE_NO_CHANNEL = 2'd3;

    localparam logic [1:0] CFG_SEND_ENABLED = 2'd0;
    localparam logic [1:0] CFG_RED_ENABLED  = 2'd1;
    localparam logic [1:0] CFG_BLUE_ENABLED = 2'd2;

    typedef struct packed {
        logic send_enabled;
        logic red_enabled;
        logic blue_enabled;
    } rbs_cfg_t;

    typedef struct packed {
        logic [1:0]  action;
        logic [31:0] now_ms;
        logic        head_valid;
        logic        ack_channel;
    } rbs_item_t;

    typedef struct packed {
        logic        tx_busy;
        logic [3:0]  retry_count;
        logic [31:0] next_retry_time;
        logic [1:0]  last_sent_chan;
        logic        last_acked_chan;
        logic [7:0]  punch_counter;
        logic [7:0]  message_counter;
    } rbs_state_t;

    typedef struct packed {
        logic       start_tx;
        logic       tx_channel;
        logic [7:0] message_seq;
        logic [7:0] punch_seq;
        logic       pop_head;
        logic [1:0] pop_cause;
    } rbs_result_t;

endpackage

// File: rtl/core/rbs_step.sv
// ----------------------------------------------------------------------------
// Retransmit backoff scheduler step logic
// Computes the next scheduling state and the result word for one event.
// ----------------------------------------------------------------------------
module rbs_step (
    input  rbs_pkg::rbs_cfg_t    cfg,
    input  rbs_pkg::rbs_state_t  state,
    input  rbs_pkg::rbs_item_t   item,
    output rbs_pkg::rbs_state_t  state_next,
    output rbs_pkg::rbs_result_t result
);
    import rbs_pkg::*;

    logic [1:0]  ack_code;
    logic        ack_on;
    logic [1:0]  pref_chan;
    logic [1:0]  red_fix;
    logic [1:0]  pick_chan;
    logic        pick_on;
    logic [3:0]  retry_inc;
    logic [3:0]  shift_amt;
    logic [31:0] delay;
    logic        time_reached;

    always_comb
    begin
        ack_code = item.ack_channel ? CH_BLUE : CH_RED;
        ack_on   = item.ack_channel ? cfg.blue_enabled : cfg.red_enabled;

        if (state.last_sent_chan == CH_NONE)
        begin
            pref_chan = state.last_acked_chan ? CH_BLUE : CH_RED;
        end
        else if (state.last_sent_chan == CH_RED)
        begin
            pref_chan = CH_BLUE;
        end
        else
        begin
            pref_chan = CH_RED;
        end
        red_fix   = (pref_chan == CH_RED && !cfg.red_enabled) ? CH_BLUE : pref_chan;
        pick_chan = (red_fix == CH_BLUE && !cfg.blue_enabled) ? CH_RED : red_fix;
        pick_on   = (pick_chan == CH_RED) ? cfg.red_enabled : cfg.blue_enabled;

        retry_inc    = state.retry_count + 4'd1;
        shift_amt    = retry_inc - 4'd1;
        delay        = (retry_inc < 4'(MAX_RETRIES)) ? (BASE_DELAY_MS << shift_amt) : GRACE_MS;
        time_reached = item.now_ms >= state.next_retry_time;
    end

    always_comb
    begin
        state_next = state;
        result     = '0;

        case (item.action) inside
            ACT_DONE, ACT_ABORT:
            begin
                state_next.tx_busy = 1'b0;
            end
            ACT_ACK:
            begin
                if (item.head_valid && ack_on && state.last_sent_chan == ack_code)
                begin
                    state_next.last_acked_chan = item.ack_channel;
                    state_next.retry_count     = 4'd0;
                    state_next.next_retry_time = 32'd0;
                    state_next.last_sent_chan  = CH_NONE;
                    result.pop_head            = 1'b1;
                    result.pop_cause           = CAUSE_ACKED;
                end
            end
            default:
            begin
                if (cfg.send_enabled && !state.tx_busy && item.head_valid)
                begin
                    if (state.retry_count >= 4'(MAX_RETRIES))
                    begin
                        if (time_reached)
                        begin
                            state_next.retry_count     = 4'd0;
                            state_next.next_retry_time = 32'd0;
                            state_next.last_sent_chan  = CH_NONE;
                            result.pop_head            = 1'b1;
                            result.pop_cause           = CAUSE_EXHAUSTED;
                        end
                    end
                    else if (state.retry_count == 4'd0 || time_reached)
                    begin
                        if (!pick_on)
                        begin
                            state_next.retry_count     = 4'd0;
                            state_next.next_retry_time = 32'd0;
                            state_next.last_sent_chan  = CH_NONE;
                            result.pop_head            = 1'b1;
                            result.pop_cause           = CAUSE_NO_CHANNEL;
                        end
                        else
                        begin
                            if (state.retry_count == 4'd0)
                            begin
                                state_next.punch_counter = state.punch_counter + 8'd1;
                            end
                            state_next.message_counter = state.message_counter + 8'd1;
                            state_next.tx_busy         = 1'b1;
                            state_next.retry_count     = retry_inc;
                            state_next.last_sent_chan  = pick_chan;
                            state_next.next_retry_time = item.now_ms + delay;
                            result.start_tx            = 1'b1;
                            result.tx_channel          = (pick_chan == CH_BLUE);
                            result.message_seq         = state_next.message_counter;
                            result.punch_seq           = state_next.punch_counter;
                        end
                    end
                end
            end
        endcase
    end

endmodule

// File: rtl/core/retransmit_backoff_scheduler_unit.sv
// ----------------------------------------------------------------------------
// Retransmit backoff scheduler unit
// Stop-and-wait retransmit control with exponential backoff over two channels.
// ----------------------------------------------------------------------------
// The unit accepts one event word per clock cycle and returns exactly one
// result word for each: an input register holds the event, and the step
// logic updates the scheduling state and loads the result register at the
// same edge. The sustained rate of one word per cycle, while the output is
// not stalled, is set by that state update. While a result waits at the output,
// the input register still takes one more word. Configuration writes are
// always ready and take effect at the next edge.
`include "assert_macros.svh"

module retransmit_backoff_scheduler_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic        cfg_data,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [1:0]  action,
    input  logic [31:0] now_ms,
    input  logic        head_valid,
    input  logic        ack_channel,
    output logic        out_valid,
    input  logic        out_ready,
    output logic        start_tx,
    output logic        tx_channel,
    output logic [7:0]  message_seq,
    output logic [7:0]  punch_seq,
    output logic        pop_head,
    output logic [1:0]  pop_cause
);
    import rbs_pkg::*;

    rbs_cfg_t    cfg_reg;
    rbs_cfg_t    cfg_next;
    rbs_state_t  state_reg;
    rbs_state_t  state_next;
    rbs_item_t   item_reg;
    rbs_result_t result_reg;
    rbs_result_t step_result;
    logic        item_valid_reg;
    logic        item_valid_next;
    logic        out_valid_reg;
    logic        out_valid_next;
    logic        advance;
    logic        in_fire;

    assign cfg_ready = 1'b1;
    assign advance   = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready  = !item_valid_reg || advance;
    assign in_fire   = in_valid && in_ready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_SEND_ENABLED: cfg_next.send_enabled = cfg_data;
                CFG_RED_ENABLED:  cfg_next.red_enabled  = cfg_data;
                CFG_BLUE_ENABLED: cfg_next.blue_enabled = cfg_data;
                default:          cfg_next = cfg_reg;
            endcase
        end
        item_valid_next = in_fire ? 1'b1 : (advance ? 1'b0 : item_valid_reg);
        out_valid_next  = advance ? 1'b1 : (out_ready ? 1'b0 : out_valid_reg);
    end

    rbs_step u_step (
        .cfg        (cfg_reg),
        .state      (state_reg),
        .item       (item_reg),
        .state_next (state_next),
        .result     (step_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.send_enabled <= 1'b0;
            cfg_reg.red_enabled  <= 1'b1;
            cfg_reg.blue_enabled <= 1'b1;
            state_reg            <= '0;
            item_valid_reg       <= 1'b0;
            out_valid_reg        <= 1'b0;
        end
        else
        begin
            cfg_reg        <= cfg_next;
            item_valid_reg <= item_valid_next;
            out_valid_reg  <= out_valid_next;
            if (advance)
            begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            item_reg.action      <= action;
            item_reg.now_ms      <= now_ms;
            item_reg.head_valid  <= head_valid;
            item_reg.ack_channel <= ack_channel;
        end
        if (advance)
        begin
            result_reg <= step_result;
        end
    end

    assign out_valid   = out_valid_reg;
    assign start_tx    = result_reg.start_tx;
    assign tx_channel  = result_reg.tx_channel;
    assign message_seq = result_reg.message_seq;
    assign punch_seq   = result_reg.punch_seq;
    assign pop_head    = result_reg.pop_head;
    assign pop_cause   = result_reg.pop_cause;

    `ASSERT_NEVER(a_no_start_and_pop, clk, rst_n, out_valid_reg && result_reg.start_tx && result_reg.pop_head, "start and pop in one word")
    `ASSERT_NEVER(a_retry_bound, clk, rst_n, state_reg.retry_count > 4'(MAX_RETRIES), "retry count past limit")
    `ASSERT_PROP(a_pop_cause, clk, rst_n, out_valid_reg |-> (result_reg.pop_head == (result_reg.pop_cause != CAUSE_NONE)), "pop flag and cause disagree")
    `ASSERT_PROP(a_start_sets_busy, clk, rst_n, (advance && step_result.start_tx) |=> state_reg.tx_busy, "start did not mark busy")

endmodule

// File: tb/sv/tb_retransmit_backoff_scheduler_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Retransmit backoff scheduler unit testbench
// Drives event words and configuration writes into the scheduler and checks
// every result word against a cycle-free model of the retransmit and backoff
// rules. A directed part covers the idle, busy, ack and channel-disable cases.
// Random phases follow under several channel settings, with random gaps on
// the input and random stalls on the output.
// ----------------------------------------------------------------------------
module tb_retransmit_backoff_scheduler_unit;

    import rbs_pkg::*;

    localparam int unsigned CYCLE_LIMIT = 1000000;

    class backoff_scoreboard;
        logic        send_en;
        logic        red_en;
        logic        blue_en;
        logic        tx_busy;
        logic [3:0]  retries;
        logic [31:0] retry_due;
        logic [1:0]  last_sent;
        logic        last_acked;
        logic [7:0]  punch_cnt;
        logic [7:0]  msg_cnt;
        rbs_result_t outcomes[$];
        int          errors;
        int          checked;
        int          starts;
        int          pops[4];

        function new();
            send_en    = 1'b0;
            red_en     = 1'b1;
            blue_en    = 1'b1;
            tx_busy    = 1'b0;
            retries    = '0;
            retry_due  = '0;
            last_sent  = CH_NONE;
            last_acked = 1'b0;
            punch_cnt  = '0;
            msg_cnt    = '0;
            errors     = 0;
            checked    = 0;
            starts     = 0;
            foreach (pops[i])
                pops[i] = 0;
        endfunction

        function void write_reg(logic [1:0] idx, logic val);
            case (idx)
                CFG_SEND_ENABLED: send_en = val;
                CFG_RED_ENABLED:  red_en  = val;
                CFG_BLUE_ENABLED: blue_en = val;
                default: ;
            endcase
        endfunction

        function logic chan_enabled(logic [1:0] ch);
            return (ch == CH_RED) ? red_en : blue_en;
        endfunction

        function rbs_result_t drop_head(logic [1:0] cause);
            rbs_result_t r;
            r           = '0;
            r.pop_head  = 1'b1;
            r.pop_cause = cause;
            retries     = '0;
            retry_due   = '0;
            last_sent   = CH_NONE;
            return r;
        endfunction

        function rbs_result_t step_scheduler(rbs_item_t ev);
            rbs_result_t r;
            logic [1:0]  ack_ch;
            logic [1:0]  ch;
            logic [31:0] delay;
            r = '0;
            ack_ch = ev.ack_channel ? CH_BLUE : CH_RED;
            case (ev.action) inside
                ACT_DONE, ACT_ABORT:
                    tx_busy = 1'b0;
                ACT_ACK:
                    if (ev.head_valid && chan_enabled(ack_ch) && last_sent == ack_ch)
                    begin
                        last_acked = ev.ack_channel;
                        r = drop_head(CAUSE_ACKED);
                    end
                default:
                    if (send_en && !tx_busy && ev.head_valid)
                    begin
                        if (retries >= MAX_RETRIES)
                        begin
                            if (ev.now_ms >= retry_due)
                                r = drop_head(CAUSE_EXHAUSTED);
                        end
                        else if (retries == 0 || ev.now_ms >= retry_due)
                        begin
                            if (last_sent == CH_NONE)
                                ch = last_acked ? CH_BLUE : CH_RED;
                            else if (last_sent == CH_RED)
                                ch = CH_BLUE;
                            else
                                ch = CH_RED;
                            if (ch == CH_RED && !red_en)
                                ch = CH_BLUE;
                            if (ch == CH_BLUE && !blue_en)
                                ch = CH_RED;
                            if (!chan_enabled(ch))
                                r = drop_head(CAUSE_NO_CHANNEL);
                            else
                            begin
                                if (retries == 0)
                                    punch_cnt++;
                                msg_cnt++;
                                tx_busy   = 1'b1;
                                retries   = retries + 4'd1;
                                last_sent = ch;
                                if (retries < MAX_RETRIES)
                                    delay = BASE_DELAY_MS << (retries - 4'd1);
                                else
                                    delay = GRACE_MS;
                                retry_due     = ev.now_ms + delay;
                                r.start_tx    = 1'b1;
                                r.tx_channel  = (ch == CH_BLUE);
                                r.message_seq = msg_cnt;
                                r.punch_seq   = punch_cnt;
                            end
                        end
                    end
            endcase
            return r;
        endfunction

        function void note_event(rbs_item_t ev);
            outcomes.push_back(step_scheduler(ev));
        endfunction

        function void compare_field(string name, logic [31:0] exp, logic [31:0] act);
            if (exp !== act)
            begin
                errors++;
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp, act);
            end
        endfunction

        function void check_result(rbs_result_t got);
            rbs_result_t exp;
            if (outcomes.size() == 0)
            begin
                errors++;
                $display("%0t: result word with nothing expected", $time);
                return;
            end
            exp = outcomes.pop_front();
            checked++;
            compare_field("start_tx", 32'(exp.start_tx), 32'(got.start_tx));
            compare_field("tx_channel", 32'(exp.tx_channel), 32'(got.tx_channel));
            compare_field("message_seq", 32'(exp.message_seq), 32'(got.message_seq));
            compare_field("punch_seq", 32'(exp.punch_seq), 32'(got.punch_seq));
            compare_field("pop_head", 32'(exp.pop_head), 32'(got.pop_head));
            compare_field("pop_cause", 32'(exp.pop_cause), 32'(got.pop_cause));
            if (exp.start_tx)
                starts++;
            if (exp.pop_head)
                pops[exp.pop_cause]++;
        endfunction
    endclass

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        cfg_valid   = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index   = '0;
    logic        cfg_data    = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_ready;
    logic [1:0]  action      = ACT_POLL;
    logic [31:0] now_ms      = '0;
    logic        head_valid  = 1'b0;
    logic        ack_channel = 1'b0;
    logic        out_valid;
    logic        out_ready   = 1'b0;
    logic        start_tx;
    logic        tx_channel;
    logic [7:0]  message_seq;
    logic [7:0]  punch_seq;
    logic        pop_head;
    logic [1:0]  pop_cause;

    backoff_scoreboard sb;
    logic        idle_on     = 1'b1;
    logic [31:0] clock_ms    = '0;
    int unsigned stall_left  = 0;
    int unsigned cycles      = 0;
    int          words_sent  = 0;
    int          cfg_writes  = 0;
    logic [2:0]  plan [0:5]  = '{3'b111, 3'b110, 3'b101, 3'b100, 3'b011, 3'b111};

    retransmit_backoff_scheduler_unit DUT (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .action      (action),
        .now_ms      (now_ms),
        .head_valid  (head_valid),
        .ack_channel (ack_channel),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .start_tx    (start_tx),
        .tx_channel  (tx_channel),
        .message_seq (message_seq),
        .punch_seq   (punch_seq),
        .pop_head    (pop_head),
        .pop_cause   (pop_cause)
    );

    always #2 clk = ~clk;

    function automatic int unsigned idle_gap();
        int unsigned roll;
        roll = $urandom_range(0, 99);
        if (!idle_on || roll < 70)
            return 0;
        if (roll < 96)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles", $time, cycles);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (stall_left != 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else
        begin
            out_ready  <= 1'b1;
            stall_left <= idle_gap();
        end
    end

    always @(posedge clk)
    begin
        rbs_result_t got;
        if (rst_n && out_valid === 1'b1 && out_ready === 1'b1)
        begin
            got.start_tx    = start_tx;
            got.tx_channel  = tx_channel;
            got.message_seq = message_seq;
            got.punch_seq   = punch_seq;
            got.pop_head    = pop_head;
            got.pop_cause   = pop_cause;
            sb.check_result(got);
        end
    end

    task automatic set_reg(logic [1:0] idx, logic val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge clk); while (cfg_ready !== 1'b1);
        sb.write_reg(idx, val);
        cfg_writes++;
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_word(rbs_item_t ev);
        int unsigned g;
        in_valid    <= 1'b1;
        action      <= ev.action;
        now_ms      <= ev.now_ms;
        head_valid  <= ev.head_valid;
        ack_channel <= ev.ack_channel;
        do @(posedge clk); while (in_ready !== 1'b1);
        sb.note_event(ev);
        words_sent++;
        g = idle_gap();
        if (g != 0)
        begin
            in_valid <= 1'b0;
            repeat (g) @(posedge clk);
        end
    endtask

    task automatic wait_drain();
        in_valid <= 1'b0;
        while (sb.outcomes.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    function automatic rbs_item_t next_event();
        rbs_item_t   ev;
        int unsigned roll;
        roll = $urandom_range(0, 99);
        ev.head_valid  = ($urandom_range(0, 19) != 0);
        ev.ack_channel = (sb.last_sent == CH_BLUE);
        if ($urandom_range(0, 4) == 0)
            ev.ack_channel = 1'($urandom_range(0, 1));
        if (sb.tx_busy)
            ev.action = (roll < 70) ? ACT_DONE : (roll < 85) ? ACT_ABORT :
                        (roll < 93) ? ACT_ACK : ACT_POLL;
        else
            ev.action = (roll < 80) ? ACT_POLL : (roll < 88) ? ACT_ACK :
                        (roll < 94) ? ACT_DONE : ACT_ABORT;
        roll = $urandom_range(0, 99);
        if (roll < 45)
            clock_ms += $urandom_range(0, 20);
        else if (roll < 80)
            clock_ms = sb.retry_due - 32'd1 + $urandom_range(0, 2);
        else if (roll < 97)
            clock_ms += $urandom_range(0, 700);
        else
            clock_ms = 32'hFFFF_FFFF - $urandom_range(0, 200);
        ev.now_ms = clock_ms;
        if ($urandom_range(0, 99) < 6)
        begin
            ev.action      = 2'($urandom_range(0, 3));
            ev.now_ms      = $urandom;
            ev.head_valid  = 1'($urandom_range(0, 1));
            ev.ack_channel = 1'($urandom_range(0, 1));
        end
        return ev;
    endfunction

    initial
    begin
        int n;
        sb = new();
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Send mode is off after reset, so none of these words may act.
        send_word('{ACT_POLL, 32'd0, 1'b1, 1'b0});
        send_word('{ACT_ACK, 32'd0, 1'b1, 1'b0});
        send_word('{ACT_DONE, 32'hFFFF_FFFF, 1'b1, 1'b1});
        send_word('{ACT_ABORT, 32'd0, 1'b0, 1'b0});
        wait_drain();
        set_reg(CFG_SEND_ENABLED, 1'b1);

        send_word('{ACT_POLL, 32'd5, 1'b0, 1'b0});
        send_word('{ACT_POLL, 32'd5, 1'b1, 1'b0});
        send_word('{ACT_POLL, 32'd100, 1'b1, 1'b0});
        send_word('{ACT_ACK, 32'd100, 1'b1, 1'b1});
        send_word('{ACT_ACK, 32'd100, 1'b0, 1'b0});
        send_word('{ACT_DONE, 32'd100, 1'b1, 1'b0});
        send_word('{ACT_POLL, 32'd60, 1'b1, 1'b0});
        send_word('{ACT_POLL, 32'd69, 1'b1, 1'b0});
        send_word('{ACT_ACK, 32'd70, 1'b1, 1'b1});
        send_word('{ACT_ABORT, 32'd71, 1'b1, 1'b0});
        send_word('{ACT_POLL, 32'hFFFF_FFFF, 1'b1, 1'b1});
        send_word('{ACT_DONE, 32'hFFFF_FFFF, 1'b1, 1'b1});
        wait_drain();
        set_reg(CFG_BLUE_ENABLED, 1'b0);

        send_word('{ACT_ACK, 32'd0, 1'b1, 1'b1});
        send_word('{ACT_POLL, 32'd100, 1'b1, 1'b0});
        send_word('{ACT_DONE, 32'd101, 1'b1, 1'b0});
        wait_drain();
        set_reg(CFG_RED_ENABLED, 1'b0);

        send_word('{ACT_POLL, 32'hFFFF_FFFF, 1'b1, 1'b0});
        wait_drain();

        plan[5] = {1'b1, 2'($urandom_range(0, 3))};
        for (int p = 0; p < 6; p++)
        begin
            wait_drain();
            idle_on = (p != 2);
            set_reg(CFG_SEND_ENABLED, plan[p][2]);
            set_reg(CFG_RED_ENABLED, plan[p][1]);
            set_reg(CFG_BLUE_ENABLED, plan[p][0]);
            n = plan[p][2] ? 310 : 100;
            for (int i = 0; i < n; i++)
                send_word(next_event());
        end

        wait_drain();
        repeat (10) @(posedge clk);
        if (sb.outcomes.size() != 0)
        begin
            $display("%0t: %0d expected result words never arrived", $time, sb.outcomes.size());
            sb.errors += sb.outcomes.size();
        end
        $display("Covered %0d event words and %0d configuration writes; %0d results checked.",
                 words_sent, cfg_writes, sb.checked);
        $display("Saw %0d sends and pops by ack %0d, by exhaustion %0d, by no channel %0d.",
                 sb.starts, sb.pops[CAUSE_ACKED], sb.pops[CAUSE_EXHAUSTED],
                 sb.pops[CAUSE_NO_CHANNEL]);
        if (sb.errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule
